[sv/udclk_pkg.sv]
package udclk_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [5:0]  SecMax      = 6'd59;
  localparam logic [5:0]  MinMax      = 6'd59;
  localparam logic [5:0]  HourMax     = 6'd23;
  localparam logic [15:0] TpsReset    = 16'd3;
  localparam logic [7:0]  DotPattern  = 8'h80;
  localparam logic [7:0]  SelectBase  = 8'b1111_1110;

  localparam logic [2:0] DigSecOnes  = 3'd0;
  localparam logic [2:0] DigSecTens  = 3'd1;
  localparam logic [2:0] DigDotLow   = 3'd2;
  localparam logic [2:0] DigMinOnes  = 3'd3;
  localparam logic [2:0] DigMinTens  = 3'd4;
  localparam logic [2:0] DigDotHigh  = 3'd5;
  localparam logic [2:0] DigHourOnes = 3'd6;
  localparam logic [2:0] DigHourTens = 3'd7;

  typedef struct packed {
    logic run_off;
    logic count_down;
    logic adjust_down;
    logic press_hour;
    logic press_minute;
    logic press_second;
  } tick_req_t;

  typedef struct packed {
    logic [2:0] digit_position;
    logic [7:0] digit_select_n;
    logic [7:0] segments;
    logic       last_digit;
  } digit_req_t;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } snapshot_t;

  function automatic logic [5:0] wrap_up(logic [5:0] v, logic [5:0] max);
    return (v >= max) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(logic [5:0] v, logic [5:0] max);
    return (v == 6'd0 || v > max) ? max : v - 6'd1;
  endfunction

  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(logic [5:0] v);
    logic [5:0] base;
    base = 6'(tens_of(v)) * 6'd10;
    return 4'(v - base);
  endfunction

  function automatic logic [7:0] seg_of(logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3f;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5b;
      4'd3:    p = 8'h4f;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6d;
      4'd6:    p = 8'h7d;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7f;
      default: p = 8'h6f;
    endcase
    return p;
  endfunction

endpackage

[sv/up_down_clock_with_display_scan_unit.sv]
// Up/down 24-hour clock with an eight-digit seven-segment display scan.
// Input channel (in_valid_i/in_ready_o/in_req_i): one request per refresh tick
// carrying the switch levels. Output channel (out_valid_o/out_ready_i/out_req_o):
// eight digit requests per tick, positions 0 to 7, built from the time held
// before that tick; last_digit marks position 7.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes ticks_per_second;
// always ready, write it only while the block is idle.
// The first digit of a tick passes through the snapshot queue, the scanner's
// current-time register and its output register. Throughput: one digit per
// cycle while out_ready_i is high, set by the digit scanner's output register.
// The time update itself finishes in the cycle the tick is accepted.
// A two-entry queue of time snapshots sits between the tick front end and the
// digit scanner, so new ticks are taken while digits are still going out.
// Reset: time 00:00:00, running, prescaler cleared, ticks_per_second 3.
// Receiver stall: the current digit holds on the output, the scanner stops,
// the queue fills, and in_ready_o drops once it is full.
module up_down_clock_with_display_scan_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  udclk_pkg::tick_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output udclk_pkg::digit_req_t out_req_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);
  import udclk_pkg::*;

  logic      q_full, q_push, q_empty, q_pop;
  snapshot_t q_wdata, q_rdata;

  udclk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  udclk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  udclk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

[sv/udclk_front.sv]
module udclk_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  udclk_pkg::tick_req_t  in_req_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output udclk_pkg::snapshot_t  q_data_o
);
  import udclk_pkg::*;

  logic [15:0] tps_q;
  logic [15:0] tick_q, tick_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic        run_q, run_d;
  logic        accept;
  logic [15:0] tick_inc;
  logic [5:0]  h6;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign q_push_o    = accept;
  assign q_data_o    = '{seconds: sec_q, minutes: min_q, hours: hour_q};
  assign tick_inc    = tick_q + 16'd1;

  always_comb begin
    tick_d = tick_q;
    sec_d  = sec_q;
    min_d  = min_q;
    h6     = {1'b0, hour_q};
    if (run_q) begin
      tick_d = tick_inc;
      if (tick_inc >= tps_q) begin
        tick_d = '0;
        if (in_req_i.count_down) begin
          if (sec_q == 6'd0) begin
            if (min_q == 6'd0) begin
              h6 = wrap_down(h6, HourMax);
            end
            min_d = wrap_down(min_q, MinMax);
          end
          sec_d = wrap_down(sec_q, SecMax);
        end else begin
          sec_d = wrap_up(sec_q, SecMax);
          if (sec_d == 6'd0) begin
            min_d = wrap_up(min_q, MinMax);
            if (min_d == 6'd0) begin
              h6 = wrap_up(h6, HourMax);
            end
          end
        end
      end
    end
    run_d = !in_req_i.run_off;
    if (in_req_i.adjust_down) begin
      if (in_req_i.press_hour)   h6    = wrap_down(h6, HourMax);
      if (in_req_i.press_minute) min_d = wrap_down(min_d, MinMax);
      if (in_req_i.press_second) sec_d = wrap_down(sec_d, SecMax);
    end else begin
      if (in_req_i.press_hour)   h6    = wrap_up(h6, HourMax);
      if (in_req_i.press_minute) min_d = wrap_up(min_d, MinMax);
      if (in_req_i.press_second) sec_d = wrap_up(sec_d, SecMax);
    end
    hour_d = h6[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q  <= TpsReset;
      tick_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      run_q  <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tps_q <= cfg_data_i;
      end
      if (accept) begin
        tick_q <= tick_d;
        sec_q  <= sec_d;
        min_q  <= min_d;
        hour_q <= hour_d;
        run_q  <= run_d;
      end
    end
  end

endmodule

[sv/udclk_queue.sv]
module udclk_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  udclk_pkg::snapshot_t  push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output udclk_pkg::snapshot_t  pop_data_o
);
  import udclk_pkg::*;

  snapshot_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, rd_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o     = cnt_q == QueueCntW'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

[sv/udclk_back.sv]
module udclk_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  udclk_pkg::snapshot_t  q_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output udclk_pkg::digit_req_t out_req_o
);
  import udclk_pkg::*;

  snapshot_t  cur_q;
  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  digit_req_t out_q, out_d;
  logic       adv, load;
  logic [7:0] pat;

  assign adv     = !out_valid_q || out_ready_i;
  assign load    = !q_empty_i && (!busy_q || (adv && cnt_q == DigHourTens));
  assign q_pop_o = load;

  always_comb begin
    case (cnt_q)
      DigSecOnes:  pat = seg_of(ones_of(cur_q.seconds));
      DigSecTens:  pat = seg_of(tens_of(cur_q.seconds));
      DigMinOnes:  pat = seg_of(ones_of(cur_q.minutes));
      DigMinTens:  pat = seg_of(tens_of(cur_q.minutes));
      DigHourOnes: pat = seg_of(ones_of({1'b0, cur_q.hours}));
      DigHourTens: pat = seg_of(tens_of({1'b0, cur_q.hours}));
      DigDotLow,
      DigDotHigh:  pat = DotPattern;
      default:     pat = DotPattern;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_d.digit_position = cnt_q;
        out_d.digit_select_n = SelectBase << cnt_q | ~(8'hff << cnt_q);
        out_d.segments       = pat;
        out_d.last_digit     = cnt_q == DigHourTens;
        cnt_d                = cnt_q + 3'd1;
        if (cnt_q == DigHourTens) begin
          busy_d = 1'b0;
        end
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = DigSecOnes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
